FILE: hdl/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg: shared types and constants of the script token scanner
// Token codes, scan modes, keyword table and the per-byte bundle layout
// passed from the scanner front end through the queue to the token emitter.
// ----------------------------------------------------------------------------
package stsc_pkg;

    // Widths of the internal offset and run-length counters
    localparam int POS_BITS  = 32;
    localparam int LEN_BITS  = 16;
    localparam int LINE_BITS = 24;

    // Port field widths
    localparam int KIND_BITS  = 6;
    localparam int ERR_BITS   = 2;
    localparam int START_BITS = 32;
    localparam int TLEN_BITS  = 16;

    localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    // Bundle queue depth
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // Keywords are recognized from at most this many leading bytes
    localparam int PREFIX_BYTES = 6;
    localparam int NUM_KW       = 16;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd0;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd3;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd4;
    localparam logic [KIND_BITS-1:0] K_DOT     = 6'd5;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd6;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd7;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd8;
    localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd9;
    localparam logic [KIND_BITS-1:0] K_STAR    = 6'd10;
    localparam logic [KIND_BITS-1:0] K_BANG    = 6'd11;
    localparam logic [KIND_BITS-1:0] K_EQUAL   = 6'd13;
    localparam logic [KIND_BITS-1:0] K_GREATER = 6'd15;
    localparam logic [KIND_BITS-1:0] K_LESS    = 6'd17;
    localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd19;
    localparam logic [KIND_BITS-1:0] K_STRING  = 6'd20;
    localparam logic [KIND_BITS-1:0] K_NUMBER  = 6'd21;
    localparam logic [KIND_BITS-1:0] K_KW_BASE = 6'd22;
    localparam logic [KIND_BITS-1:0] K_ERROR   = 6'd38;
    localparam logic [KIND_BITS-1:0] K_EOF     = 6'd39;

    // Error codes
    localparam logic [ERR_BITS-1:0] E_NONE   = 2'd0;
    localparam logic [ERR_BITS-1:0] E_UNTERM = 2'd1;
    localparam logic [ERR_BITS-1:0] E_BADCH  = 2'd2;

    // Source characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5a;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // Keyword text, first byte in the low bits, zero padded; kind = base + index
    localparam logic [8*PREFIX_BYTES-1:0] KW_TEXT [NUM_KW] = '{
        48'h0000_0064_6e61,  // and
        48'h0073_7361_6c63,  // class
        48'h0000_6573_6c65,  // else
        48'h0065_736c_6166,  // false
        48'h0000_0072_6f66,  // for
        48'h0000_006e_7566,  // fun
        48'h0000_0000_6669,  // if
        48'h0000_006c_696e,  // nil
        48'h0000_0000_726f,  // or
        48'h0074_6e69_7270,  // print
        48'h6e72_7574_6572,  // return
        48'h0072_6570_7573,  // super
        48'h0000_7369_6874,  // this
        48'h0000_6575_7274,  // true
        48'h0000_0072_6176,  // var
        48'h0065_6c69_6877   // while
    };

    // Scan modes
    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_NUM,
        M_NUM_DOT,
        M_FRAC,
        M_STR,
        M_COMMENT,
        M_SLASH,
        M_BANG,
        M_EQUAL,
        M_LESS,
        M_GREATER
    } t_mode;

    // One finished token, line kept once per bundle
    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [ERR_BITS-1:0]   err;
        logic [START_BITS-1:0] start;
        logic [TLEN_BITS-1:0]  len;
    } t_token;

    // Tokens caused by one source byte, in emission order
    typedef struct packed {
        logic [1:0]           cnt;
        logic [LINE_BITS-1:0] line;
        t_token [2:0]         tok;
    } t_bundle;

    // Queue status seen by the front end and the emitter
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Build a token, clamping the length to the port width
    function automatic t_token mk_tok(
        input logic [KIND_BITS-1:0] kind,
        input logic [ERR_BITS-1:0]  err,
        input logic [POS_BITS-1:0]  start,
        input logic [LEN_BITS-1:0]  len
    );
        t_token t;
        t.kind  = kind;
        t.err   = err;
        t.start = START_BITS'(start);
        t.len   = (32'(len) > 32'(16'hFFFF)) ? 16'hFFFF : TLEN_BITS'(len);
        return t;
    endfunction

endpackage

FILE: hdl/script_token_scanner_top.sv
// ----------------------------------------------------------------------------
// script_token_scanner_top: streaming token scanner for a small script language
// Source bytes in, tokens out, with a bundle queue between scanner and emitter.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while the bundle queue is not full (byte 0
// ends the text and restarts offsets and lines) and emits one token per cycle
// while the sink is ready. A byte that completes two or three tokens (a
// pending token closed by a one-byte token, a number followed by a lone dot, or a
// pending token at end of text followed by EOF) needs one output transfer per
// token, since the output register drains one token per cycle. A four-entry
// bundle queue absorbs these bursts, so input is only stalled when the queue
// fills. A byte's tokens are registered in the queue, then in the output register.
module script_token_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [5:0] token_kind, [7:6] error_code,
                                     // [39:8] token_start, [55:40] token_length,
                                     // [79:56] token_line
    output logic        o_m_tlast    // is_last
);

    stsc_pkg::t_q_status             q_status;
    stsc_pkg::t_bundle               push_data;
    stsc_pkg::t_bundle               head;
    logic                            push;
    logic                            pop;
    stsc_pkg::t_token                tok;
    logic [stsc_pkg::LINE_BITS-1:0]  line;

    // Scan source bytes into token bundles
    stsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_ch       (i_s_tdata),
        .o_ready    (o_s_tready),
        .i_q_status (q_status),
        .o_push     (push),
        .o_bundle   (push_data)
    );

    // Buffer bundles
    stsc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    // Emit tokens one per transaction
    stsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_tok      (tok),
        .o_line     (line),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {line, tok.len, tok.start, tok.err, tok.kind};

endmodule

FILE: hdl/stsc_front.sv
// ----------------------------------------------------------------------------
// stsc_front: byte scanner
// Accepts one source byte per transaction, tracks scan mode, offsets and lines,
// and produces the bundle of tokens that the byte completes.
// ----------------------------------------------------------------------------
module stsc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_ch,
    output logic                 o_ready,
    input  stsc_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output stsc_pkg::t_bundle    o_bundle
);

    localparam int PB = stsc_pkg::PREFIX_BYTES;

    stsc_pkg::t_mode                     r_mode, n_mode;
    logic [8*PB-1:0]                     r_prefix, n_prefix;
    logic [stsc_pkg::LEN_BITS-1:0]       r_len, n_len;
    logic [stsc_pkg::POS_BITS-1:0]       r_start, n_start;
    logic [stsc_pkg::POS_BITS-1:0]       r_pos;
    logic [stsc_pkg::LINE_BITS-1:0]      r_line;

    logic                                accept;
    logic                                line_inc;
    logic                                fresh;
    logic                                p0_v, p1_v, f_v;
    stsc_pkg::t_token                    p0, p1, f;
    logic [stsc_pkg::LEN_BITS-1:0]       len_inc, len_inc2;
    logic [stsc_pkg::KIND_BITS-1:0]      id_kind;
    logic                                is_alpha, is_digit;
    logic [1:0]                          cnt;

    // One-character operator kind of a pending operator mode
    function automatic logic [stsc_pkg::KIND_BITS-1:0] op_kind(input stsc_pkg::t_mode m);
        logic [stsc_pkg::KIND_BITS-1:0] k;
        unique case (m)
            stsc_pkg::M_BANG:  k = stsc_pkg::K_BANG;
            stsc_pkg::M_EQUAL: k = stsc_pkg::K_EQUAL;
            stsc_pkg::M_LESS:  k = stsc_pkg::K_LESS;
            default:           k = stsc_pkg::K_GREATER;
        endcase
        return k;
    endfunction

    // Kind of a single punctuation character
    function automatic logic [stsc_pkg::KIND_BITS-1:0] single_kind(input logic [7:0] c);
        logic [stsc_pkg::KIND_BITS-1:0] k;
        unique case (c)
            stsc_pkg::CH_LPAREN: k = stsc_pkg::K_LPAREN;
            stsc_pkg::CH_RPAREN: k = stsc_pkg::K_RPAREN;
            stsc_pkg::CH_LBRACE: k = stsc_pkg::K_LBRACE;
            stsc_pkg::CH_RBRACE: k = stsc_pkg::K_RBRACE;
            stsc_pkg::CH_COMMA:  k = stsc_pkg::K_COMMA;
            stsc_pkg::CH_DOT:    k = stsc_pkg::K_DOT;
            stsc_pkg::CH_MINUS:  k = stsc_pkg::K_MINUS;
            stsc_pkg::CH_PLUS:   k = stsc_pkg::K_PLUS;
            stsc_pkg::CH_SEMI:   k = stsc_pkg::K_SEMI;
            default:             k = stsc_pkg::K_STAR;
        endcase
        return k;
    endfunction

    // Mode entered by a character that opens a run
    function automatic stsc_pkg::t_mode run_mode(input logic [7:0] c);
        stsc_pkg::t_mode m;
        unique case (c)
            stsc_pkg::CH_SLASH: m = stsc_pkg::M_SLASH;
            stsc_pkg::CH_BANG:  m = stsc_pkg::M_BANG;
            stsc_pkg::CH_EQ:    m = stsc_pkg::M_EQUAL;
            stsc_pkg::CH_LT:    m = stsc_pkg::M_LESS;
            stsc_pkg::CH_GT:    m = stsc_pkg::M_GREATER;
            default:            m = stsc_pkg::M_STR;
        endcase
        return m;
    endfunction

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // Character classes
    assign is_digit = (i_ch >= stsc_pkg::CH_0) && (i_ch <= stsc_pkg::CH_9);
    assign is_alpha = ((i_ch >= stsc_pkg::CH_LA) && (i_ch <= stsc_pkg::CH_LZ)) ||
                      ((i_ch >= stsc_pkg::CH_UA) && (i_ch <= stsc_pkg::CH_UZ)) ||
                      (i_ch == stsc_pkg::CH_USCORE);

    // Saturating run growth by one and by two
    assign len_inc  = (r_len == stsc_pkg::LEN_MAX) ? r_len : r_len + 1'b1;
    assign len_inc2 = (r_len >= stsc_pkg::LEN_MAX - 1'b1) ? stsc_pkg::LEN_MAX
                                                          : r_len + 2'd2;

    // Keyword lookup on the stored prefix; zero padding makes length implicit
    always_comb begin
        id_kind = stsc_pkg::K_IDENT;
        if (32'(r_len) <= 32'(PB)) begin
            for (int k = 0; k < stsc_pkg::NUM_KW; k++) begin
                if (r_prefix == stsc_pkg::KW_TEXT[k]) begin
                    id_kind = stsc_pkg::K_KW_BASE + stsc_pkg::KIND_BITS'(k);
                end
            end
        end
    end

    // Next state and the tokens of this byte
    always_comb begin
        n_mode   = r_mode;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_start  = r_start;
        line_inc = 1'b0;
        fresh    = 1'b0;
        p0_v     = 1'b0;
        p1_v     = 1'b0;
        p0       = '0;
        p1       = '0;
        f_v      = 1'b0;
        f        = '0;

        unique case (r_mode)
            stsc_pkg::M_IDENT: begin
                if (is_alpha || is_digit) begin
                    for (int b = 0; b < PB; b++) begin
                        if (32'(r_len) == 32'(b)) begin
                            n_prefix[8*b +: 8] = i_ch;
                        end
                    end
                    n_len = len_inc;
                end else begin
                    p0_v  = 1'b1;
                    p0    = stsc_pkg::mk_tok(id_kind, stsc_pkg::E_NONE, r_start, r_len);
                    fresh = 1'b1;
                end
            end
            stsc_pkg::M_NUM: begin
                if (is_digit) begin
                    n_len = len_inc;
                end else if (i_ch == stsc_pkg::CH_DOT) begin
                    n_mode = stsc_pkg::M_NUM_DOT;
                end else begin
                    p0_v  = 1'b1;
                    p0    = stsc_pkg::mk_tok(stsc_pkg::K_NUMBER, stsc_pkg::E_NONE,
                                             r_start, r_len);
                    fresh = 1'b1;
                end
            end
            stsc_pkg::M_NUM_DOT: begin
                if (is_digit) begin
                    n_len  = len_inc2;
                    n_mode = stsc_pkg::M_FRAC;
                end else begin
                    // Held dot was not a fraction: number, then the dot itself
                    p0_v  = 1'b1;
                    p0    = stsc_pkg::mk_tok(stsc_pkg::K_NUMBER, stsc_pkg::E_NONE,
                                             r_start, r_len);
                    p1_v  = 1'b1;
                    p1    = stsc_pkg::mk_tok(stsc_pkg::K_DOT, stsc_pkg::E_NONE,
                                             r_pos - 1'b1, stsc_pkg::LEN_BITS'(1));
                    fresh = 1'b1;
                end
            end
            stsc_pkg::M_FRAC: begin
                if (is_digit) begin
                    n_len = len_inc;
                end else begin
                    p0_v  = 1'b1;
                    p0    = stsc_pkg::mk_tok(stsc_pkg::K_NUMBER, stsc_pkg::E_NONE,
                                             r_start, r_len);
                    fresh = 1'b1;
                end
            end
            stsc_pkg::M_STR: begin
                if (i_ch == stsc_pkg::CH_NUL) begin
                    p0_v  = 1'b1;
                    p0    = stsc_pkg::mk_tok(stsc_pkg::K_ERROR, stsc_pkg::E_UNTERM,
                                             r_start, r_len);
                    fresh = 1'b1;
                end else begin
                    line_inc = (i_ch == stsc_pkg::CH_LF);
                    n_len    = len_inc;
                    if (i_ch == stsc_pkg::CH_QUOTE) begin
                        p0_v   = 1'b1;
                        p0     = stsc_pkg::mk_tok(stsc_pkg::K_STRING, stsc_pkg::E_NONE,
                                                  r_start, len_inc);
                        n_mode = stsc_pkg::M_IDLE;
                    end
                end
            end
            stsc_pkg::M_COMMENT: begin
                fresh = (i_ch == stsc_pkg::CH_LF) || (i_ch == stsc_pkg::CH_NUL);
            end
            stsc_pkg::M_SLASH: begin
                if (i_ch == stsc_pkg::CH_SLASH) begin
                    n_mode = stsc_pkg::M_COMMENT;
                end else begin
                    p0_v  = 1'b1;
                    p0    = stsc_pkg::mk_tok(stsc_pkg::K_SLASH, stsc_pkg::E_NONE,
                                             r_start, stsc_pkg::LEN_BITS'(1));
                    fresh = 1'b1;
                end
            end
            stsc_pkg::M_BANG, stsc_pkg::M_EQUAL, stsc_pkg::M_LESS,
            stsc_pkg::M_GREATER: begin
                p0_v = 1'b1;
                if (i_ch == stsc_pkg::CH_EQ) begin
                    n_mode = stsc_pkg::M_IDLE;
                    p0     = stsc_pkg::mk_tok(op_kind(r_mode) + 1'b1, stsc_pkg::E_NONE,
                                              r_start, stsc_pkg::LEN_BITS'(2));
                end else begin
                    p0    = stsc_pkg::mk_tok(op_kind(r_mode), stsc_pkg::E_NONE,
                                             r_start, stsc_pkg::LEN_BITS'(1));
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // Scan the byte as the start of a new token
        if (fresh) begin
            n_mode = stsc_pkg::M_IDLE;
            case (i_ch)
                stsc_pkg::CH_NUL: begin
                    f_v = 1'b1;
                    f   = stsc_pkg::mk_tok(stsc_pkg::K_EOF, stsc_pkg::E_NONE, r_pos, '0);
                end
                stsc_pkg::CH_SPACE, stsc_pkg::CH_CR, stsc_pkg::CH_TAB: begin
                    f_v = 1'b0;
                end
                stsc_pkg::CH_LF: begin
                    line_inc = 1'b1;
                end
                stsc_pkg::CH_LPAREN, stsc_pkg::CH_RPAREN, stsc_pkg::CH_LBRACE,
                stsc_pkg::CH_RBRACE, stsc_pkg::CH_COMMA, stsc_pkg::CH_DOT,
                stsc_pkg::CH_MINUS, stsc_pkg::CH_PLUS, stsc_pkg::CH_SEMI,
                stsc_pkg::CH_STAR: begin
                    f_v = 1'b1;
                    f   = stsc_pkg::mk_tok(single_kind(i_ch), stsc_pkg::E_NONE, r_pos,
                                           stsc_pkg::LEN_BITS'(1));
                end
                stsc_pkg::CH_SLASH, stsc_pkg::CH_BANG, stsc_pkg::CH_EQ,
                stsc_pkg::CH_LT, stsc_pkg::CH_GT, stsc_pkg::CH_QUOTE: begin
                    n_mode  = run_mode(i_ch);
                    n_start = r_pos;
                    n_len   = stsc_pkg::LEN_BITS'(1);
                end
                default: begin
                    if (is_alpha) begin
                        n_mode   = stsc_pkg::M_IDENT;
                        n_start  = r_pos;
                        n_len    = stsc_pkg::LEN_BITS'(1);
                        n_prefix = (8*PB)'(i_ch);
                    end else if (is_digit) begin
                        n_mode  = stsc_pkg::M_NUM;
                        n_start = r_pos;
                        n_len   = stsc_pkg::LEN_BITS'(1);
                    end else begin
                        f_v = 1'b1;
                        f   = stsc_pkg::mk_tok(stsc_pkg::K_ERROR, stsc_pkg::E_BADCH, r_pos,
                                               stsc_pkg::LEN_BITS'(1));
                    end
                end
            endcase
        end
    end

    // Pack tokens in order: pending ones first, then the fresh one
    always_comb begin
        cnt = 2'(p0_v) + 2'(p1_v) + 2'(f_v);
        o_bundle.cnt    = cnt;
        o_bundle.line   = r_line;
        o_bundle.tok[0] = p0_v ? p0 : f;
        o_bundle.tok[1] = p1_v ? p1 : f;
        o_bundle.tok[2] = f;
        o_push          = accept && (cnt != 2'd0);
    end

    // Advance scan state on each accepted byte; end of text restarts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && (i_ch == stsc_pkg::CH_NUL))) begin
            r_mode   <= stsc_pkg::M_IDLE;
            r_prefix <= '0;
            r_len    <= '0;
            r_start  <= '0;
            r_pos    <= '0;
            r_line   <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_prefix <= n_prefix;
            r_len    <= n_len;
            r_start  <= n_start;
            r_pos    <= r_pos + 1'b1;
            if (line_inc && (r_line != stsc_pkg::LINE_MAX)) begin
                r_line <= r_line + 1'b1;
            end
        end
    end

endmodule

FILE: hdl/stsc_queue.sv
// ----------------------------------------------------------------------------
// stsc_queue: token bundle queue
// Short first-in first-out buffer of bundles between the scanner and the
// token emitter, so either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module stsc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  stsc_pkg::t_bundle    i_push_data,
    input  logic                 i_pop,
    output stsc_pkg::t_bundle    o_head,
    output stsc_pkg::t_q_status  o_status
);

    stsc_pkg::t_bundle                   r_mem [stsc_pkg::QDEPTH];
    logic [stsc_pkg::QPTR_BITS-1:0]      r_wr, r_rd;
    logic [stsc_pkg::QCNT_BITS-1:0]      r_cnt;
    logic                                do_pop;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == stsc_pkg::QCNT_BITS'(stsc_pkg::QDEPTH));
    assign o_head         = r_mem[r_rd];
    assign do_pop         = i_pop && !o_status.empty;

    // Store pushed bundles
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/stsc_back.sv
// ----------------------------------------------------------------------------
// stsc_back: token emitter
// Walks the tokens of the head bundle one per cycle, while the output register
// is empty or being taken, into the output register and pops the bundle after its last token.
// ----------------------------------------------------------------------------
module stsc_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  stsc_pkg::t_bundle                      i_head,
    input  stsc_pkg::t_q_status                    i_q_status,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output stsc_pkg::t_token                       o_tok,
    output logic [stsc_pkg::LINE_BITS-1:0]         o_line,
    output logic                                   o_last
);

    logic [1:0]        r_idx;
    logic              r_valid;
    stsc_pkg::t_token  r_tok;
    logic [stsc_pkg::LINE_BITS-1:0] r_line;
    logic              r_last;
    logic              load;
    logic              at_end;

    assign load   = !i_q_status.empty && (!r_valid || i_ready);
    assign at_end = (r_idx == i_head.cnt - 1'b1);
    assign o_pop  = load && at_end;

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_line  = r_line;
    assign o_last  = r_last;

    // Output handshake and token index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the selected token into the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= i_head.tok[r_idx];
            r_line <= i_head.line;
            r_last <= at_end;
        end
    end

endmodule

FILE: tb/sv/tb_script_token_scanner_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_script_token_scanner_top: self-checking bench for the script token scanner
// Streams source texts through the byte port, predicts every token with an
// in-bench lexer model and checks each output transaction field by field.
// ----------------------------------------------------------------------------
module tb_script_token_scanner_top;

    // Idle cycles with no transaction on either side before the run is aborted
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 360;

    // One predicted or observed token
    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic        last;
    } t_lex_tok;

    // Lexer model plus the store of tokens still to come out of the block
    class token_tracker;
        string kw_words[16] = '{"and", "class", "else", "false", "for", "fun", "if",
                                "nil", "or", "print", "return", "super", "this",
                                "true", "var", "while"};
        stsc_pkg::t_mode mode;
        logic [47:0] prefix;
        logic [15:0] run_len;
        logic [31:0] run_start;
        logic [31:0] pos;
        logic [23:0] line;
        t_lex_tok    step_toks[$];
        t_lex_tok    pending_tokens[$];
        int          failures;
        int          reports;
        int          checked;
        int          bytes_seen;
        int          triples;
        int          longest;
        bit [39:0]   kinds_seen;

        function new();
            clear();
        endfunction

        function void clear();
            mode      = stsc_pkg::M_IDLE;
            prefix    = '0;
            run_len   = '0;
            run_start = '0;
            pos       = '0;
            line      = '0;
        endfunction

        function int outstanding();
            return pending_tokens.size();
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= stsc_pkg::CH_LA && c <= stsc_pkg::CH_LZ) ||
                   (c >= stsc_pkg::CH_UA && c <= stsc_pkg::CH_UZ) ||
                   c == stsc_pkg::CH_USCORE;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= stsc_pkg::CH_0 && c <= stsc_pkg::CH_9;
        endfunction

        // Queue one token for this byte; a byte yields three at most
        function void emit(logic [5:0] kind, logic [1:0] err, logic [31:0] start,
                           logic [15:0] len);
            t_lex_tok t;
            if (step_toks.size() >= 3) return;
            t.kind  = kind;
            t.err   = err;
            t.start = start;
            t.len   = len;
            t.line  = line;
            t.last  = 1'b0;
            step_toks.push_back(t);
        endfunction

        function void grow();
            if (run_len != 16'hFFFF) run_len++;
        endfunction

        function void bump_line();
            if (line != stsc_pkg::LINE_MAX) line++;
        endfunction

        function void open_run(stsc_pkg::t_mode m);
            mode      = m;
            run_start = pos;
            run_len   = 16'd1;
        endfunction

        // Keyword lookup from the kept prefix and the identifier length
        function logic [5:0] word_kind();
            string w;
            bit    hit;
            if (run_len > 16'd6) return stsc_pkg::K_IDENT;
            for (int i = 0; i < 16; i++) begin
                w = kw_words[i];
                if (w.len() != int'(run_len)) continue;
                hit = 1'b1;
                for (int k = 0; k < w.len(); k++)
                    if (prefix[8*k +: 8] != w[k]) hit = 1'b0;
                if (hit) return stsc_pkg::K_KW_BASE + 6'(i);
            end
            return stsc_pkg::K_IDENT;
        endfunction

        // Scan a byte with no token in progress
        function void scan_fresh(logic [7:0] c);
            mode = stsc_pkg::M_IDLE;
            case (c)
                stsc_pkg::CH_NUL:    emit(stsc_pkg::K_EOF, stsc_pkg::E_NONE, pos, 16'd0);
                stsc_pkg::CH_SPACE, stsc_pkg::CH_CR, stsc_pkg::CH_TAB: ;
                stsc_pkg::CH_LF:     bump_line();
                stsc_pkg::CH_LPAREN: emit(stsc_pkg::K_LPAREN, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_RPAREN: emit(stsc_pkg::K_RPAREN, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_LBRACE: emit(stsc_pkg::K_LBRACE, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_RBRACE: emit(stsc_pkg::K_RBRACE, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_COMMA:  emit(stsc_pkg::K_COMMA, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_DOT:    emit(stsc_pkg::K_DOT, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_MINUS:  emit(stsc_pkg::K_MINUS, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_PLUS:   emit(stsc_pkg::K_PLUS, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_SEMI:   emit(stsc_pkg::K_SEMI, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_STAR:   emit(stsc_pkg::K_STAR, stsc_pkg::E_NONE, pos, 16'd1);
                stsc_pkg::CH_SLASH:  open_run(stsc_pkg::M_SLASH);
                stsc_pkg::CH_BANG:   open_run(stsc_pkg::M_BANG);
                stsc_pkg::CH_EQ:     open_run(stsc_pkg::M_EQUAL);
                stsc_pkg::CH_LT:     open_run(stsc_pkg::M_LESS);
                stsc_pkg::CH_GT:     open_run(stsc_pkg::M_GREATER);
                stsc_pkg::CH_QUOTE:  open_run(stsc_pkg::M_STR);
                default: begin
                    if (is_alpha(c)) begin
                        open_run(stsc_pkg::M_IDENT);
                        prefix = {40'd0, c};
                    end else if (is_digit(c)) begin
                        open_run(stsc_pkg::M_NUM);
                    end else begin
                        emit(stsc_pkg::K_ERROR, stsc_pkg::E_BADCH, pos, 16'd1);
                    end
                end
            endcase
        endfunction

        // Resolve a pending one-character operator against its follower
        function void op_pair(logic [7:0] c, logic [5:0] one_kind);
            if (c == stsc_pkg::CH_EQ) begin
                emit(one_kind + 6'd1, stsc_pkg::E_NONE, run_start, 16'd2);
                mode = stsc_pkg::M_IDLE;
            end else begin
                emit(one_kind, stsc_pkg::E_NONE, run_start, 16'd1);
                scan_fresh(c);
            end
        endfunction

        // Note an accepted source byte and predict the tokens it releases
        function void take_byte(logic [7:0] c);
            step_toks.delete();
            bytes_seen++;
            case (mode)
                stsc_pkg::M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (run_len < 16'd6) prefix[8*int'(run_len) +: 8] = c;
                        grow();
                    end else begin
                        emit(word_kind(), stsc_pkg::E_NONE, run_start, run_len);
                        scan_fresh(c);
                    end
                end
                stsc_pkg::M_NUM: begin
                    if (is_digit(c)) begin
                        grow();
                    end else if (c == stsc_pkg::CH_DOT) begin
                        mode = stsc_pkg::M_NUM_DOT;
                    end else begin
                        emit(stsc_pkg::K_NUMBER, stsc_pkg::E_NONE, run_start, run_len);
                        scan_fresh(c);
                    end
                end
                stsc_pkg::M_NUM_DOT: begin
                    if (is_digit(c)) begin
                        grow();
                        grow();
                        mode = stsc_pkg::M_FRAC;
                    end else begin
                        emit(stsc_pkg::K_NUMBER, stsc_pkg::E_NONE, run_start, run_len);
                        emit(stsc_pkg::K_DOT, stsc_pkg::E_NONE, pos - 32'd1, 16'd1);
                        scan_fresh(c);
                    end
                end
                stsc_pkg::M_FRAC: begin
                    if (is_digit(c)) begin
                        grow();
                    end else begin
                        emit(stsc_pkg::K_NUMBER, stsc_pkg::E_NONE, run_start, run_len);
                        scan_fresh(c);
                    end
                end
                stsc_pkg::M_STR: begin
                    if (c == stsc_pkg::CH_NUL) begin
                        emit(stsc_pkg::K_ERROR, stsc_pkg::E_UNTERM, run_start, run_len);
                        scan_fresh(c);
                    end else begin
                        if (c == stsc_pkg::CH_LF) bump_line();
                        grow();
                        if (c == stsc_pkg::CH_QUOTE) begin
                            emit(stsc_pkg::K_STRING, stsc_pkg::E_NONE, run_start, run_len);
                            mode = stsc_pkg::M_IDLE;
                        end
                    end
                end
                stsc_pkg::M_COMMENT: begin
                    if (c == stsc_pkg::CH_LF || c == stsc_pkg::CH_NUL) scan_fresh(c);
                end
                stsc_pkg::M_SLASH: begin
                    if (c == stsc_pkg::CH_SLASH) begin
                        mode = stsc_pkg::M_COMMENT;
                    end else begin
                        emit(stsc_pkg::K_SLASH, stsc_pkg::E_NONE, run_start, 16'd1);
                        scan_fresh(c);
                    end
                end
                stsc_pkg::M_BANG:    op_pair(c, stsc_pkg::K_BANG);
                stsc_pkg::M_EQUAL:   op_pair(c, stsc_pkg::K_EQUAL);
                stsc_pkg::M_LESS:    op_pair(c, stsc_pkg::K_LESS);
                stsc_pkg::M_GREATER: op_pair(c, stsc_pkg::K_GREATER);
                default:             scan_fresh(c);
            endcase

            // Mark the final token of this byte and hand all of them on
            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
            if (step_toks.size() == 3) triples++;
            foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);

            if (c == stsc_pkg::CH_NUL) clear();
            else pos++;
        endfunction

        function void check_field(string name, longint unsigned want,
                                  longint unsigned got);
            if (want != got) begin
                failures++;
                if (reports < 30)
                    $display("%0t: token %0d %s mismatch, expected %0h, actual %0h",
                             $time, checked, name, want, got);
                reports++;
            end
        endfunction

        // Compare one output transaction with the oldest predicted token
        function void match_token(logic [79:0] data, logic last);
            t_lex_tok want;
            if (pending_tokens.size() == 0) begin
                failures++;
                if (reports < 30)
                    $display("%0t: unexpected token, expected none, actual %0h last %0b",
                             $time, data, last);
                reports++;
                return;
            end
            want = pending_tokens.pop_front();
            check_field("kind", want.kind, data[5:0]);
            check_field("error", want.err, data[7:6]);
            check_field("start", want.start, data[39:8]);
            check_field("length", want.len, data[55:40]);
            check_field("line", want.line, data[79:56]);
            check_field("last", want.last, last);
            if (data[5:0] < 6'd40) kinds_seen[data[5:0]] = 1'b1;
            if (int'(data[55:40]) > longest) longest = int'(data[55:40]);
            checked++;
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;

    token_tracker tracker = new();
    logic [7:0]   text_buf[$];
    bit           send_calm;
    bit           sink_calm;
    int           bytes_sent;
    int           texts_sent;
    int           idle_cycles;

    script_token_scanner_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Gap length: mostly none or short, a few long, none at all when calm
    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sample both handshakes, predict first, then check
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) tracker.take_byte(s_tdata);
            if (m_tvalid && m_tready) tracker.match_token(m_tdata, m_tlast);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d tokens outstanding",
                         $time, WATCHDOG_LIMIT, tracker.outstanding());
                $display("script_token_scanner_top verification failed");
                $finish;
            end
        end
    end

    // Output side: ready bursts broken by stalls of random length
    initial begin
        int hold;
        forever begin
            if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
            hold = pick_gap(sink_calm);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    function automatic void put(logic [7:0] c);
        text_buf.push_back(c);
    endfunction

    function automatic void put_word(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    function automatic logic [7:0] word_char(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'(stsc_pkg::CH_LA + r);
        if (r < 52) return 8'(stsc_pkg::CH_UA + (r - 26));
        if (r == 52) return stsc_pkg::CH_USCORE;
        return 8'(stsc_pkg::CH_0 + (r - 53));
    endfunction

    function automatic void put_digits(int n);
        repeat (n) put(8'(stsc_pkg::CH_0 + $urandom_range(0, 9)));
    endfunction

    // Any nonzero byte except the one given, with extra line feeds
    function automatic logic [7:0] body_byte(logic [7:0] banned);
        logic [7:0] c;
        if (banned != stsc_pkg::CH_LF && $urandom_range(0, 6) == 0) return stsc_pkg::CH_LF;
        do c = 8'($urandom_range(1, 255)); while (c == banned);
        return c;
    endfunction

    // Append one random lexical fragment, mostly well formed
    function automatic void add_fragment();
        string kw;
        string ops;
        int    r;
        int    n;
        ops = "(){},.-+;*/!=<>";
        r   = $urandom_range(0, 99);
        if (r < 18) begin
            // keyword, sometimes clipped or extended so it becomes an identifier
            kw = tracker.kw_words[$urandom_range(0, 15)];
            n  = $urandom_range(0, 9);
            if (n == 0) kw = kw.substr(0, kw.len() - 2);
            put_word(kw);
            if (n == 1) put(word_char(1'b0));
        end else if (r < 33) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            put(word_char(1'b1));
            repeat (n - 1) put(word_char(1'b0));
        end else if (r < 45) begin
            put_digits($urandom_range(1, 5));
            n = $urandom_range(0, 99);
            if (n < 40) begin
                put(stsc_pkg::CH_DOT);
                put_digits($urandom_range(1, 3));
            end else if (n < 60) begin
                // trailing dot: resolved by whatever comes next
                put(stsc_pkg::CH_DOT);
            end
        end else if (r < 55) begin
            put(stsc_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 8)) put(body_byte(stsc_pkg::CH_QUOTE));
            put(stsc_pkg::CH_QUOTE);
        end else if (r < 68) begin
            put(ops[$urandom_range(0, ops.len() - 1)]);
        end else if (r < 76) begin
            n = $urandom_range(0, 3);
            put(n == 0 ? stsc_pkg::CH_BANG : n == 1 ? stsc_pkg::CH_EQ :
                n == 2 ? stsc_pkg::CH_LT : stsc_pkg::CH_GT);
            put(stsc_pkg::CH_EQ);
        end else if (r < 83) begin
            put(stsc_pkg::CH_SLASH);
            put(stsc_pkg::CH_SLASH);
            repeat ($urandom_range(0, 8)) put(body_byte(stsc_pkg::CH_LF));
            put(stsc_pkg::CH_LF);
        end else if (r < 92) begin
            repeat ($urandom_range(1, 3)) begin
                n = $urandom_range(0, 3);
                put(n == 0 ? stsc_pkg::CH_SPACE : n == 1 ? stsc_pkg::CH_TAB :
                    n == 2 ? stsc_pkg::CH_CR : stsc_pkg::CH_LF);
            end
        end else begin
            put(8'($urandom_range(1, 255)));
        end
    endfunction

    // One source text: fragments, an optional open ending, then the end byte
    function automatic void build_text();
        int r;
        repeat ($urandom_range(2, 14)) begin
            add_fragment();
            r = $urandom_range(0, 9);
            if (r < 4) put(stsc_pkg::CH_SPACE);
            else if (r == 4) put(stsc_pkg::CH_LF);
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            put(stsc_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6)) put(body_byte(stsc_pkg::CH_QUOTE));
        end else if (r == 1) begin
            put(stsc_pkg::CH_SLASH);
            put(stsc_pkg::CH_SLASH);
            repeat ($urandom_range(0, 4)) put(body_byte(stsc_pkg::CH_LF));
        end else if (r == 2) begin
            put_digits($urandom_range(1, 3));
            put(stsc_pkg::CH_DOT);
        end
        put(stsc_pkg::CH_NUL);
    endfunction

    // Offer one byte, holding it until the block takes it
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (text_buf.size() > 0) send_byte(text_buf.pop_front());
        texts_sent++;
    endtask

    // Hold the input until every predicted token has come out
    task automatic drain_all();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: keyword, number then dot then paren, operators, stray high
        // byte, comment, unterminated string over a line feed, then number-dot at end of text
        put_word("if 1.(>=/ ");
        put(8'h80);
        put_word("//c\n\"q\n");
        put(stsc_pkg::CH_NUL);
        put_word("99.");
        put(stsc_pkg::CH_NUL);
        send_text();
        drain_all();

        // Random texts, sometimes sent back to back, sometimes fully drained
        while (bytes_sent < RANDOM_BYTES) begin
            send_calm = ($urandom_range(0, 3) == 0);
            build_text();
            send_text();
            if ($urandom_range(0, 3) == 0) drain_all();
        end
        send_calm = 1'b0;

        drain_all();
        repeat (8) @(posedge clk);

        if (tracker.outstanding() != 0) begin
            tracker.failures++;
            $display("%0t: %0d predicted tokens never came out", $time,
                     tracker.outstanding());
        end
        $display("Covered %0d source bytes in %0d texts, %0d tokens checked, %0d of 40 kinds",
                 tracker.bytes_seen, texts_sent, tracker.checked,
                 $countones(tracker.kinds_seen));
        $display("Bytes releasing three tokens: %0d, longest token length: %0d",
                 tracker.triples, tracker.longest);
        if (tracker.failures == 0) begin
            $display("script_token_scanner_top verification clean");
        end else begin
            $display("script_token_scanner_top verification failed");
        end
        $finish;
    end

endmodule
